FILE: sv/amrd_pkg.sv
// Package for the actuator mixer: field widths, register indexes and mode flag positions.
// Depends on nothing; used by the interfaces and every module of the mixer.
`timescale 1ns / 1ps
package amrd_pkg;
    localparam int Chans = 8;
    localparam int CmdW = 16;
    localparam int CfgW = 64;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_MODE    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_DAMP    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TRIM    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SURFACE = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_VTAIL   = 3'd4;

    localparam int F_DROLL = 0;
    localparam int F_DPITCH = 1;
    localparam int F_DYAW = 2;
    localparam int F_TUNE = 3;
    localparam int F_AC = 4;
    localparam int F_TT = 5;
    localparam int F_FT = 6;
    localparam int F_ELEVON = 7;
    localparam int F_FLAPERON = 8;
    localparam int F_VTAIL = 9;

    typedef struct packed {
        logic signed [15:0] power_cmd;
        logic signed [15:0] roll_cmd;
        logic signed [15:0] pitch_cmd;
        logic signed [15:0] yaw_cmd;
        logic signed [15:0] flaps_cmd;
        logic signed [15:0] gear_cmd;
        logic signed [15:0] aux1_cmd;
        logic signed [15:0] aux2_cmd;
        logic [47:0]        body_rates;
        logic signed [15:0] tune_knob;
        logic               throttle_armed;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_channel_0;
        logic signed [15:0] out_channel_1;
        logic signed [15:0] out_channel_2;
        logic signed [15:0] out_channel_3;
        logic signed [15:0] out_channel_4;
        logic signed [15:0] out_channel_5;
        logic signed [15:0] out_channel_6;
        logic signed [15:0] out_channel_7;
    } t_out_item;

    // Matrix entries are Q3.12 but may be a negated -32768, so 17 bits.
    typedef logic signed [16:0] t_coef;
    typedef t_coef [Chans-1:0][Chans-1:0] t_matrix;
    // Damped commands: 16-bit command plus up to about 2^23 of damping.
    typedef logic signed [27:0] t_dcmd;
    typedef t_dcmd [Chans-1:0] t_vec;

    typedef struct packed {
        logic [9:0]  mode_flags;
        logic [47:0] damping_gains;
        logic [47:0] trim_gains;
        logic [63:0] surface_gains;
        logic [31:0] vtail_gains;
    } t_cfg;
endpackage

FILE: sv/amrd_in_if.sv
// Valid/ready channel interface carrying one command set per transaction.
// Depends on amrd_pkg.
`timescale 1ns / 1ps
interface amrd_in_if;
    import amrd_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/amrd_out_if.sv
// Valid/ready channel interface carrying eight actuator outputs per transaction.
// Depends on amrd_pkg.
`timescale 1ns / 1ps
interface amrd_out_if;
    import amrd_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/actuator_mixer_with_rate_damping.sv
// Top level of the actuator mixer with rate damping: config registers and pipeline control.
// Depends on amrd_pkg, amrd_in_if, amrd_out_if, amrd_matrix, amrd_damp and amrd_mix.
//
//  Channel   Direction  Carries
//  s_in      sink       eight commands, body rates, tune knob, arm bit
//  m_out     source     eight saturated actuator outputs
//  config    write      mode flags and four gain registers (index 0..4)
//
// The pipeline is five stages deep: tune times gain, times rate, damped sum,
// matrix products, row sums with rounding and saturation. One transaction
// enters per cycle while the output is not stalled.
// Reset is synchronous and active low; it clears valid bits and restores the
// register defaults. The whole pipeline advances as one when the last stage
// is empty or taken, so a stall on the output holds every stage in place.
`timescale 1ns / 1ps
module actuator_mixer_with_rate_damping (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    amrd_in_if.sink                       s_in,
    amrd_out_if.source                    m_out,
    input  logic                          i_cfg_we,
    input  logic [amrd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [amrd_pkg::CfgW-1:0]     i_cfg_data
);
    import amrd_pkg::*;

    localparam int Depth = 5;

    t_cfg            r_cfg;
    logic [Depth-1:0] r_vld;
    logic            w_en;
    t_matrix         w_matrix;
    t_vec            w_vec;
    logic            w_armed;

    // Advance when the output slot is free or is being taken this cycle.
    assign w_en = !r_vld[Depth-1] || m_out.ready;
    assign s_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cfg.mode_flags <= 10'd7;
            r_cfg.damping_gains <= 48'h0333_0333_0333;
            r_cfg.trim_gains <= '0;
            r_cfg.surface_gains <= '0;
            r_cfg.vtail_gains <= '0;
        end else begin
            if (w_en) r_vld <= {r_vld[Depth-2:0], s_in.valid};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE:    r_cfg.mode_flags <= i_cfg_data[9:0];
                    REG_DAMP:    r_cfg.damping_gains <= i_cfg_data[47:0];
                    REG_TRIM:    r_cfg.trim_gains <= i_cfg_data[47:0];
                    REG_SURFACE: r_cfg.surface_gains <= i_cfg_data;
                    REG_VTAIL:   r_cfg.vtail_gains <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    // The matrix depends only on configuration; users must keep it stable while items are in flight (unenforced).
    amrd_matrix u_matrix (
        .i_clk    (i_clk),
        .i_cfg    (r_cfg),
        .o_matrix (w_matrix)
    );

    amrd_damp u_damp (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_item  (s_in.data),
        .o_vec   (w_vec),
        .o_armed (w_armed)
    );

    amrd_mix u_mix (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_matrix (w_matrix),
        .i_vec    (w_vec),
        .i_armed  (w_armed),
        .o_item   (m_out.data)
    );

    assign m_out.valid = r_vld[Depth-1];
endmodule

FILE: sv/amrd_matrix.sv
// Builds the registered mixing matrix from the mode flags and gain registers.
// Depends on amrd_pkg.
`timescale 1ns / 1ps
module amrd_matrix (
    input  logic              i_clk,
    input  amrd_pkg::t_cfg    i_cfg,
    output amrd_pkg::t_matrix o_matrix
);
    import amrd_pkg::*;

    t_matrix n_m;
    t_matrix r_m;

    function automatic t_coef gx(input logic [15:0] g);
        gx = t_coef'(signed'(g));
    endfunction

    always_comb begin
        logic vt;
        logic [9:0] f;
        f = i_cfg.mode_flags;
        vt = f[F_VTAIL] && !f[F_ELEVON];
        for (int i = 0; i < Chans; i++) begin
            for (int j = 0; j < Chans; j++) begin
                n_m[i][j] = (i == j) ? t_coef'(4096) : t_coef'(0);
            end
        end
        if (f[F_AC]) begin
            n_m[3][1] = gx(i_cfg.trim_gains[15:0]);
            if (vt) n_m[2][1] = -gx(i_cfg.trim_gains[15:0]);
        end
        if (f[F_TT]) n_m[2][0] = gx(i_cfg.trim_gains[31:16]);
        if (f[F_FT]) begin
            n_m[2][4] = gx(i_cfg.trim_gains[47:32]);
            if (vt) n_m[3][4] = gx(i_cfg.trim_gains[47:32]);
        end
        if (f[F_ELEVON]) begin
            n_m[1][1] = gx(i_cfg.surface_gains[15:0]);
            n_m[1][2] = gx(i_cfg.surface_gains[31:16]);
            n_m[2][1] = gx(i_cfg.surface_gains[15:0]);
            n_m[2][2] = -gx(i_cfg.surface_gains[31:16]);
        end else if (f[F_FLAPERON]) begin
            n_m[1][1] = gx(i_cfg.surface_gains[47:32]);
            n_m[1][4] = gx(i_cfg.surface_gains[63:48]);
            n_m[4][1] = -gx(i_cfg.surface_gains[47:32]);
            n_m[4][4] = gx(i_cfg.surface_gains[63:48]);
        end
        if (vt) begin
            n_m[2][2] = gx(i_cfg.vtail_gains[15:0]);
            n_m[2][3] = gx(i_cfg.vtail_gains[31:16]);
            n_m[3][2] = gx(i_cfg.vtail_gains[15:0]);
            n_m[3][3] = -gx(i_cfg.vtail_gains[31:16]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
    end

    assign o_matrix = r_m;
endmodule

FILE: sv/amrd_damp.sv
// Rate damping pipeline: tune factor and gain product, then rate product, then rounding and damped sum.
// Depends on amrd_pkg. Three register stages, advanced by i_en.
`timescale 1ns / 1ps
module amrd_damp (
    input  logic              i_clk,
    input  logic              i_en,
    input  amrd_pkg::t_cfg    i_cfg,
    input  amrd_pkg::t_in_item i_item,
    output amrd_pkg::t_vec    o_vec,
    output logic              o_armed
);
    import amrd_pkg::*;

    // Stage 1: tune factor times gain (17 x 16 bits).
    logic signed [32:0] r_tg [3];
    logic signed [15:0] r_rate1 [3];
    t_in_item           r_it1;
    // Stage 2: times rate.
    logic signed [48:0] r_prod [3];
    t_in_item           r_it2;
    // Stage 3: damped vector.
    t_vec               r_vec;
    logic               r_armed;

    logic signed [17:0] n_tune;
    logic signed [16:0] n_tc;
    logic signed [33:0] n_round [3];
    logic signed [27:0] n_dmp [3];
    logic [2:0]         f_en;

    always_comb begin
        n_tune = 18'(signed'(i_item.tune_knob)) <<< 1;
        if (!i_cfg.mode_flags[F_TUNE]) n_tc = 17'sd16384;
        else if (n_tune < 0) n_tc = '0;
        else if (n_tune > 18'sd32768) n_tc = 17'sd32768;
        else n_tc = n_tune[16:0];
        f_en = i_cfg.mode_flags[2:0];
        for (int k = 0; k < 3; k++) begin
            n_round[k] = 34'((r_prod[k] + 49'sd2097152) >>> 22);
            n_dmp[k] = f_en[k] ? n_round[k][27:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_tg[k] <= 33'(n_tc * signed'(i_cfg.damping_gains[16*k +: 16]));
                r_rate1[k] <= signed'(i_item.body_rates[16*k +: 16]);
                r_prod[k] <= 49'(r_tg[k] * r_rate1[k]);
            end
            r_it1 <= i_item;
            r_it2 <= r_it1;
            r_vec[0] <= 28'(r_it2.power_cmd);
            r_vec[1] <= 28'(r_it2.roll_cmd) - n_dmp[0];
            r_vec[2] <= 28'(r_it2.pitch_cmd) + n_dmp[1];
            r_vec[3] <= 28'(r_it2.yaw_cmd) - n_dmp[2];
            r_vec[4] <= 28'(r_it2.flaps_cmd);
            r_vec[5] <= 28'(r_it2.gear_cmd);
            r_vec[6] <= 28'(r_it2.aux1_cmd);
            r_vec[7] <= 28'(r_it2.aux2_cmd);
            r_armed <= r_it2.throttle_armed;
        end
    end

    assign o_vec = r_vec;
    assign o_armed = r_armed;
endmodule

FILE: sv/amrd_mix.sv
// Mixing pipeline: products of matrix and damped vector, then row sums with rounding and saturation.
// Depends on amrd_pkg. Two register stages, advanced by i_en.
`timescale 1ns / 1ps
module amrd_mix (
    input  logic              i_clk,
    input  logic              i_en,
    input  amrd_pkg::t_matrix i_matrix,
    input  amrd_pkg::t_vec    i_vec,
    input  logic              i_armed,
    output amrd_pkg::t_out_item o_item
);
    import amrd_pkg::*;

    logic signed [44:0] r_p [Chans][Chans];
    logic               r_armed;
    logic signed [15:0] r_o [Chans];

    logic signed [47:0] n_acc [Chans];
    logic signed [35:0] n_r [Chans];
    logic signed [15:0] n_sat [Chans];

    always_comb begin
        for (int i = 0; i < Chans; i++) begin
            n_acc[i] = '0;
            for (int j = 0; j < Chans; j++) begin
                n_acc[i] = n_acc[i] + 48'(r_p[i][j]);
            end
            n_r[i] = 36'((n_acc[i] + 48'sd2048) >>> 12);
            if (n_r[i] > 36'sd32767) n_sat[i] = 16'sh7fff;
            else if (n_r[i] < -36'sd32768) n_sat[i] = 16'sh8000;
            else n_sat[i] = n_r[i][15:0];
        end
        if (!r_armed) n_sat[0] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < Chans; i++) begin
                for (int j = 0; j < Chans; j++) begin
                    r_p[i][j] <= 45'(i_matrix[i][j] * i_vec[j]);
                end
                r_o[i] <= n_sat[i];
            end
            r_armed <= i_armed;
        end
    end

    assign o_item.out_channel_0 = r_o[0];
    assign o_item.out_channel_1 = r_o[1];
    assign o_item.out_channel_2 = r_o[2];
    assign o_item.out_channel_3 = r_o[3];
    assign o_item.out_channel_4 = r_o[4];
    assign o_item.out_channel_5 = r_o[5];
    assign o_item.out_channel_6 = r_o[6];
    assign o_item.out_channel_7 = r_o[7];
endmodule
